[src/tmr_pkg.sv]
`default_nettype none

package tmr_pkg;

  // op codes carried in tuser
  localparam logic [1:0] OpLocal  = 2'd0;
  localparam logic [1:0] OpRemote = 2'd1;
  localparam logic [1:0] OpReport = 2'd2;

  // configuration register indexes
  localparam logic [2:0] RegBallOnThisSide = 3'd0;
  localparam logic [2:0] RegThisSideIsLeft = 3'd1;
  localparam logic [2:0] RegScrollShift    = 3'd2;
  localparam logic [2:0] RegSnapMode       = 3'd3;
  localparam logic [2:0] RegAxisLayout     = 3'd4;

  // snap codes
  localparam logic [1:0] SnapFree     = 2'd0;
  localparam logic [1:0] SnapVertOnly = 2'd1;
  localparam logic [1:0] SnapHorzOnly = 2'd2;

  localparam logic [2:0] MaxScrollShift = 3'd7;
  localparam logic signed [15:0] ClipPos = 16'sd127;
  localparam logic signed [15:0] ClipNeg = -16'sd127;

  typedef struct packed {
    logic       ball_on_this_side;
    logic       this_side_is_left;
    logic [2:0] scroll_shift;
    logic [1:0] snap_mode;
    logic       axis_layout;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } acc_pair_t;

  typedef struct packed {
    logic              move_wr;
    logic signed [7:0] mx;
    logic signed [7:0] my;
    logic signed [7:0] wh;
    logic signed [7:0] wv;
  } pass_out_t;

  function automatic logic signed [7:0] clip127(input logic signed [15:0] v);
    logic signed [15:0] c;
    if (v > ClipPos) begin
      c = ClipPos;
    end else if (v < ClipNeg) begin
      c = ClipNeg;
    end else begin
      c = v;
    end
    return c[7:0];
  endfunction

endpackage

`default_nettype wire

[src/trackball_motion_to_report.sv]
`default_nettype none

// Trackball motion to mouse report. Transactions with tuser OpLocal/OpRemote add
// their deltas into the local or remote saturating accumulators and give no
// output; a report transaction converts both pairs (local first, remote second,
// remote overwriting shared fields) into one output transaction. One input
// transaction is taken every cycle while no report stalls; each passes an input
// register and combinational shift/clip/add logic, and a report is then loaded into
// the output register. A report stalls in the input register only while the
// output register still holds an untaken report.
module trackball_motion_to_report (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // [15:0] delta_x, [31:16] delta_y, [32] scroll_on, [39:33] zero
  input  wire logic [39:0] s_axis_tdata,
  // [1:0] op
  input  wire logic [1:0]  s_axis_tuser,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] move_x, [15:8] move_y, [23:16] wheel_h, [31:24] wheel_v
  output      logic [31:0] m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [2:0]  cfg_wdata_i
);

  tmr_pkg::cfg_t      cfg_q;
  logic               stg_valid_q;
  logic [1:0]         stg_op_q;
  logic signed [15:0] stg_dx_q, stg_dy_q;
  logic               stg_scroll_q;
  logic               stg_adv;
  logic               in_acc;
  logic               out_valid_q;
  logic [31:0]        out_data_q, out_data_d;

  tmr_pkg::acc_pair_t local_acc, remote_acc;
  tmr_pkg::acc_pair_t local_nxt, remote_nxt;
  tmr_pkg::pass_out_t local_res, remote_res;
  logic [7:0]         mx, my, wh, wv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ball_on_this_side <= 1'b1;
      cfg_q.this_side_is_left <= 1'b0;
      cfg_q.scroll_shift      <= 3'd4;
      cfg_q.snap_mode         <= tmr_pkg::SnapFree;
      cfg_q.axis_layout       <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tmr_pkg::RegBallOnThisSide: cfg_q.ball_on_this_side <= cfg_wdata_i[0];
        tmr_pkg::RegThisSideIsLeft: cfg_q.this_side_is_left <= cfg_wdata_i[0];
        tmr_pkg::RegScrollShift:    cfg_q.scroll_shift      <= cfg_wdata_i;
        tmr_pkg::RegSnapMode:       cfg_q.snap_mode         <= cfg_wdata_i[1:0];
        tmr_pkg::RegAxisLayout:     cfg_q.axis_layout       <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // a report may not overwrite an untaken one
  assign stg_adv = stg_valid_q &&
                   !(stg_op_q == tmr_pkg::OpReport && out_valid_q && !m_axis_tready);
  assign s_axis_tready = !stg_valid_q || stg_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      stg_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stg_op_q     <= s_axis_tuser;
      stg_dx_q     <= s_axis_tdata[15:0];
      stg_dy_q     <= s_axis_tdata[31:16];
      stg_scroll_q <= s_axis_tdata[32];
    end
  end

  tmr_acc u_acc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .upd_i        (stg_adv),
    .op_i         (stg_op_q),
    .dx_i         (stg_dx_q),
    .dy_i         (stg_dy_q),
    .local_nxt_i  (local_nxt),
    .remote_nxt_i (remote_nxt),
    .local_o      (local_acc),
    .remote_o     (remote_acc)
  );

  tmr_pass u_local_pass (
    .cfg_i     (cfg_q),
    .left_i    (cfg_q.this_side_is_left),
    .scroll_i  (stg_scroll_q),
    .acc_i     (local_acc),
    .acc_nxt_o (local_nxt),
    .res_o     (local_res)
  );

  tmr_pass u_remote_pass (
    .cfg_i     (cfg_q),
    .left_i    (!cfg_q.this_side_is_left),
    .scroll_i  (stg_scroll_q ^ cfg_q.ball_on_this_side),
    .acc_i     (remote_acc),
    .acc_nxt_o (remote_nxt),
    .res_o     (remote_res)
  );

  // remote pass wins on the fields both passes write
  always_comb begin
    mx = '0;
    my = '0;
    wh = '0;
    wv = '0;
    if (local_res.move_wr) begin
      mx = local_res.mx;
      my = local_res.my;
    end else begin
      wh = local_res.wh;
      wv = local_res.wv;
    end
    if (remote_res.move_wr) begin
      mx = remote_res.mx;
      my = remote_res.my;
    end else begin
      wh = remote_res.wh;
      wv = remote_res.wv;
    end
    out_data_d = {wv, wh, my, mx};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stg_adv && stg_op_q == tmr_pkg::OpReport) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_adv && stg_op_q == tmr_pkg::OpReport) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

[src/tmr_acc.sv]
`default_nettype none

// the four motion accumulators with saturating add; a report loads the leftover values
module tmr_acc (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               upd_i,
  input  wire logic [1:0]         op_i,
  input  wire logic signed [15:0] dx_i,
  input  wire logic signed [15:0] dy_i,
  input  wire tmr_pkg::acc_pair_t local_nxt_i,
  input  wire tmr_pkg::acc_pair_t remote_nxt_i,
  output tmr_pkg::acc_pair_t      local_o,
  output tmr_pkg::acc_pair_t      remote_o
);

  tmr_pkg::acc_pair_t local_q, local_d;
  tmr_pkg::acc_pair_t remote_q, remote_d;
  tmr_pkg::acc_pair_t sel_acc;
  tmr_pkg::acc_pair_t sum;
  logic signed [16:0] sum_x, sum_y;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > 17'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -17'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  always_comb begin
    sel_acc = (op_i == tmr_pkg::OpLocal) ? local_q : remote_q;
    sum_x   = {sel_acc.x[15], sel_acc.x} + {dx_i[15], dx_i};
    sum_y   = {sel_acc.y[15], sel_acc.y} + {dy_i[15], dy_i};
    sum.x   = sat16(sum_x);
    sum.y   = sat16(sum_y);
  end

  always_comb begin
    local_d  = local_q;
    remote_d = remote_q;
    if (upd_i) begin
      unique case (op_i)
        tmr_pkg::OpLocal:  local_d  = sum;
        tmr_pkg::OpRemote: remote_d = sum;
        tmr_pkg::OpReport: begin
          local_d  = local_nxt_i;
          remote_d = remote_nxt_i;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_q  <= '0;
      remote_q <= '0;
    end else begin
      local_q  <= local_d;
      remote_q <= remote_d;
    end
  end

  assign local_o  = local_q;
  assign remote_o = remote_q;

endmodule

`default_nettype wire

[src/tmr_pass.sv]
`default_nettype none

// converts one accumulator pair into report fields and its leftover value
module tmr_pass (
  input  wire tmr_pkg::cfg_t      cfg_i,
  input  wire logic               left_i,
  input  wire logic               scroll_i,
  input  wire tmr_pkg::acc_pair_t acc_i,
  output tmr_pkg::acc_pair_t      acc_nxt_o,
  output tmr_pkg::pass_out_t      res_o
);

  logic [2:0]         sh;
  logic [2:0]         k;
  logic [15:0]        mask;
  logic signed [16:0] bias_x, bias_y;
  logic signed [16:0] shr_x, shr_y;
  logic signed [15:0] qx, qy;
  logic signed [15:0] rx, ry;
  logic signed [7:0]  cx, cy, cqx, cqy;
  logic signed [7:0]  wh, wv;

  always_comb begin
    if (cfg_i.scroll_shift == 3'd0) begin
      sh = 3'd1;
    end else if (cfg_i.scroll_shift > tmr_pkg::MaxScrollShift) begin
      sh = tmr_pkg::MaxScrollShift;
    end else begin
      sh = cfg_i.scroll_shift;
    end
    k    = sh - 3'd1;
    mask = (16'd1 << k) - 16'd1;

    // negative values get a bias so the shift truncates toward zero
    bias_x = {acc_i.x[15], acc_i.x} + (acc_i.x[15] ? $signed({1'b0, mask}) : 17'sd0);
    bias_y = {acc_i.y[15], acc_i.y} + (acc_i.y[15] ? $signed({1'b0, mask}) : 17'sd0);
    shr_x  = bias_x >>> k;
    shr_y  = bias_y >>> k;
    qx     = shr_x[15:0];
    qy     = shr_y[15:0];
    rx     = acc_i.x - (qx <<< k);
    ry     = acc_i.y - (qy <<< k);

    cx  = tmr_pkg::clip127(acc_i.x);
    cy  = tmr_pkg::clip127(acc_i.y);
    cqx = tmr_pkg::clip127(qx);
    cqy = tmr_pkg::clip127(qy);

    res_o = '0;
    res_o.move_wr = !scroll_i;
    if (cfg_i.axis_layout) begin
      res_o.mx = cx;
      res_o.my = -cy;
      wh       = cqx;
      wv       = cqy;
    end else begin
      res_o.mx = left_i ? -cy : cy;
      res_o.my = left_i ? -cx : cx;
      wh       = left_i ? -cqy : cqy;
      wv       = left_i ? cqx : -cqx;
    end
    unique case (cfg_i.snap_mode)
      tmr_pkg::SnapVertOnly: wh = '0;
      tmr_pkg::SnapHorzOnly: wv = '0;
      default: ;
    endcase
    res_o.wh = wh;
    res_o.wv = wv;

    if (scroll_i) begin
      acc_nxt_o.x = rx;
      acc_nxt_o.y = ry;
    end else begin
      acc_nxt_o = '0;
    end
  end

endmodule

`default_nettype wire

[src/tmr_checker.sv]
`default_nettype none

module tmr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

  a_no_minus128: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:0] != 8'h80) && (m_axis_tdata[15:8] != 8'h80) &&
                      (m_axis_tdata[23:16] != 8'h80) && (m_axis_tdata[31:24] != 8'h80))
    else $error("report field outside clip range");

  // a fresh report on the output must come from an accepted report transaction
  a_report_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && s_axis_tuser == tmr_pkg::OpReport, 2))
    else $error("report output without a report transaction");

endmodule

bind trackball_motion_to_report tmr_checker u_tmr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[bench/tb_trackball_motion_to_report.sv]
`default_nettype none

module tb_trackball_motion_to_report;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int WatchdogLimit = 3000;
  localparam int HoldCycles = 300;
  localparam int DrainTail = 6;
  localparam int PhaseItems = 130;

  typedef struct packed {
    logic signed [7:0] wv;
    logic signed [7:0] wh;
    logic signed [7:0] my;
    logic signed [7:0] mx;
  } report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = tmr_pkg::OpLocal;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = tmr_pkg::RegBallOnThisSide;
  logic [2:0]  cfg_wdata_i = '0;

  // shadow of the block's settings and accumulators
  tmr_pkg::cfg_t cfg_now;
  int            local_x, local_y, remote_x, remote_y;
  report_t       expected_reports[$];

  int mismatches = 0;
  int stall_cycles = 0;
  int burst_left = 0;
  bit src_gaps_on = 1'b1;
  bit hold_req = 1'b0;

  trackball_motion_to_report i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int saturate_acc(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int clip_to_report(input int v);
    if (v > 127) return 127;
    if (v < -127) return -127;
    return v;
  endfunction

  // one pass over an accumulator pair, writing only the fields of its mode
  task automatic convert_pair(inout int ax, inout int ay, input bit left, input bit scroll,
                              inout report_t rep);
    int shift_eff, div, qx, qy, h, v;
    if (!scroll) begin
      if (cfg_now.axis_layout) begin
        h = clip_to_report(ax);
        v = -clip_to_report(ay);
      end else begin
        h = clip_to_report(ay);
        v = clip_to_report(ax);
        if (left) begin
          h = -h;
          v = -v;
        end
      end
      rep.mx = 8'(h);
      rep.my = 8'(v);
      ax = 0;
      ay = 0;
    end else begin
      shift_eff = int'(cfg_now.scroll_shift);
      if (shift_eff < 1) shift_eff = 1;
      if (shift_eff > int'(tmr_pkg::MaxScrollShift)) shift_eff = int'(tmr_pkg::MaxScrollShift);
      div = 1 << (shift_eff - 1);
      // division truncates toward zero, remainder stays behind
      qx = ax / div;
      ax = ax - qx * div;
      qy = ay / div;
      ay = ay - qy * div;
      if (cfg_now.axis_layout) begin
        h = clip_to_report(qx);
        v = clip_to_report(qy);
      end else begin
        h = clip_to_report(qy);
        v = -clip_to_report(qx);
        if (left) begin
          h = -h;
          v = -v;
        end
      end
      if (cfg_now.snap_mode == tmr_pkg::SnapVertOnly) begin
        h = 0;
      end else if (cfg_now.snap_mode == tmr_pkg::SnapHorzOnly) begin
        v = 0;
      end
      rep.wh = 8'(h);
      rep.wv = 8'(v);
    end
  endtask

  task automatic track_motion(input logic [1:0] op, input logic signed [15:0] dx,
                              input logic signed [15:0] dy, input bit scroll);
    report_t rep;
    case (op)
      tmr_pkg::OpLocal: begin
        local_x = saturate_acc(local_x + int'(dx));
        local_y = saturate_acc(local_y + int'(dy));
      end
      tmr_pkg::OpRemote: begin
        remote_x = saturate_acc(remote_x + int'(dx));
        remote_y = saturate_acc(remote_y + int'(dy));
      end
      tmr_pkg::OpReport: begin
        rep = '0;
        convert_pair(local_x, local_y, cfg_now.this_side_is_left, scroll, rep);
        convert_pair(remote_x, remote_y, !cfg_now.this_side_is_left,
                     scroll ^ cfg_now.ball_on_this_side, rep);
        expected_reports.push_back(rep);
      end
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [2:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tmr_pkg::RegBallOnThisSide: cfg_now.ball_on_this_side = val[0];
      tmr_pkg::RegThisSideIsLeft: cfg_now.this_side_is_left = val[0];
      tmr_pkg::RegScrollShift:    cfg_now.scroll_shift = val;
      tmr_pkg::RegSnapMode:       cfg_now.snap_mode = val[1:0];
      tmr_pkg::RegAxisLayout:     cfg_now.axis_layout = val[0];
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [1:0] op, input logic signed [15:0] dx,
                           input logic signed [15:0] dy, input bit scroll);
    int gap;
    if (src_gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, scroll, dy, dx};
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    track_motion(op, dx, dy, scroll);
  endtask

  task automatic drain_reports();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DrainTail) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_delta();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return 16'sd32767;
      2:       return -16'sd32768;
      3, 4, 5: return 16'($urandom_range(0, 600) - 300);
      default: return 16'($urandom_range(0, 80) - 40);
    endcase
  endfunction

  task automatic test_defaults();
    send_item(tmr_pkg::OpReport, 16'sd0, 16'sd0, 1'b0);
    send_item(tmr_pkg::OpLocal, 16'sd50, -16'sd20, 1'b0);
    send_item(tmr_pkg::OpRemote, 16'sd30, 16'sd9, 1'b1);
    send_item(tmr_pkg::OpReport, 16'sd0, 16'sd0, 1'b1);
  endtask

  task automatic test_saturation();
    send_item(tmr_pkg::OpLocal, 16'sd32767, -16'sd32768, 1'b1);
    send_item(tmr_pkg::OpLocal, 16'sd32767, -16'sd32768, 1'b0);
    send_item(tmr_pkg::OpRemote, -16'sd32768, 16'sd32767, 1'b1);
    send_item(tmr_pkg::OpRemote, -16'sd32768, 16'sd32767, 1'b0);
    send_item(tmr_pkg::OpReport, -16'sd1, -16'sd1, 1'b0);
    send_item(tmr_pkg::OpReport, 16'sd0, 16'sd0, 1'b1);
  endtask

  task automatic test_unused_op();
    send_item(OpUnused, -16'sd32768, 16'sd32767, 1'b1);
    send_item(tmr_pkg::OpReport, 16'sd0, 16'sd0, 1'b0);
  endtask

  task automatic test_zero_shift();
    drain_reports();
    write_reg(tmr_pkg::RegScrollShift, 3'd0);
    send_item(tmr_pkg::OpLocal, -16'sd300, 16'sd7, 1'b0);
    send_item(tmr_pkg::OpReport, 16'sd0, 16'sd0, 1'b1);
    send_item(tmr_pkg::OpReport, 16'sd0, 16'sd0, 1'b0);
  endtask

  task automatic test_snap_codes();
    for (int snap = 1; snap <= 3; snap++) begin
      drain_reports();
      write_reg(tmr_pkg::RegSnapMode, 3'(snap));
      send_item(tmr_pkg::OpLocal, 16'sd100, -16'sd100, 1'b0);
      send_item(tmr_pkg::OpReport, 16'sd0, 16'sd0, 1'b1);
    end
  endtask

  task automatic test_hand_layout();
    drain_reports();
    write_reg(tmr_pkg::RegAxisLayout, 3'd1);
    write_reg(tmr_pkg::RegThisSideIsLeft, 3'd1);
    write_reg(tmr_pkg::RegBallOnThisSide, 3'd0);
    write_reg(tmr_pkg::RegScrollShift, 3'd7);
    send_item(tmr_pkg::OpLocal, -16'sd200, 16'sd90, 1'b0);
    send_item(tmr_pkg::OpRemote, 16'sd60, -16'sd400, 1'b0);
    send_item(tmr_pkg::OpReport, 16'sd0, 16'sd0, 1'b1);
    send_item(tmr_pkg::OpReport, 16'sd0, 16'sd0, 1'b0);
  endtask

  // output held off while local items and reports keep coming without sender gaps
  task automatic test_backpressure();
    drain_reports();
    src_gaps_on = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++) begin
      send_item(tmr_pkg::OpLocal, rand_delta(), rand_delta(), 1'b0);
      send_item(tmr_pkg::OpReport, 16'($urandom), 16'($urandom), 1'($urandom));
    end
    src_gaps_on = 1'b1;
  endtask

  task automatic test_random_settings();
    int sent, k;
    for (int p = 0; p < 9; p++) begin
      drain_reports();
      write_reg(tmr_pkg::RegBallOnThisSide, 3'(p & 1));
      write_reg(tmr_pkg::RegThisSideIsLeft, 3'((p >> 1) & 1));
      write_reg(tmr_pkg::RegAxisLayout, 3'((p >> 2) & 1));
      write_reg(tmr_pkg::RegScrollShift, 3'((p * 3) % 8));
      write_reg(tmr_pkg::RegSnapMode, 3'(p % 4));
      // no sender gaps in one phase
      src_gaps_on = (p != 5);
      sent = 0;
      while (sent < PhaseItems) begin
        k = $urandom_range(0, 5);
        repeat (k) begin
          send_item($urandom_range(0, 1) ? tmr_pkg::OpRemote : tmr_pkg::OpLocal,
                    rand_delta(), rand_delta(), 1'($urandom));
          sent++;
        end
        if ($urandom_range(0, 9) == 0) begin
          send_item(OpUnused, 16'($urandom), 16'($urandom), 1'($urandom));
        end
        send_item(tmr_pkg::OpReport, 16'($urandom), 16'($urandom), 1'($urandom));
        sent++;
      end
    end
    src_gaps_on = 1'b1;
  endtask

  initial begin
    cfg_now = '{ball_on_this_side: 1'b1, this_side_is_left: 1'b0, scroll_shift: 3'd4,
                snap_mode: tmr_pkg::SnapFree, axis_layout: 1'b0};
    local_x = 0;
    local_y = 0;
    remote_x = 0;
    remote_y = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_defaults();
    test_saturation();
    test_unused_op();
    test_zero_shift();
    test_snap_codes();
    test_hand_layout();
    test_backpressure();
    test_random_settings();
    drain_reports();
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("PASS trackball_motion_to_report");
    end else begin
      $display("FAIL trackball_motion_to_report");
    end
    $finish;
  end

  // receiver: runs of ready and stall, plus one long hold on request
  initial begin : report_sink
    int run_left, hold_left;
    bit run_val;
    run_left = 0;
    hold_left = 0;
    run_val = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          if ($urandom_range(0, 3) == 0) begin
            run_val = 1'b1;
            run_left = $urandom_range(20, 80);
          end else begin
            run_val = 1'($urandom);
            run_left = $urandom_range(1, 7);
          end
        end
        run_left--;
        m_axis_tready <= run_val;
      end
    end
  end

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch %s: expected %0d got %0d", name, $signed(want), $signed(got));
      end
    end
  endtask

  always @(posedge clk_i) begin : report_check
    report_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report transaction %h", m_axis_tdata);
      end else begin
        want = expected_reports.pop_front();
        compare_field("move_x", want.mx, got.mx);
        compare_field("move_y", want.my, got.my);
        compare_field("wheel_h", want.wh, got.wh);
        compare_field("wheel_v", want.wv, got.wv);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("FAIL trackball_motion_to_report");
      $finish;
    end
  end

endmodule

`default_nettype wire
